### rtl/tciq_pkg.sv
// Shared constants and types for the two-class insertion queue.
package tciq_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int TAG_BITS_DEF = 16;

  localparam logic [2:0] OP_PUSH   = 3'd0;
  localparam logic [2:0] OP_URGENT = 3'd1;
  localparam logic [2:0] OP_POP    = 3'd2;
  localparam logic [2:0] OP_CLOSE  = 3'd3;
  localparam logic [2:0] OP_QUERY  = 3'd4;

  localparam logic [2:0] ST_OK           = 3'd0;
  localparam logic [2:0] ST_CLOSED       = 3'd1;
  localparam logic [2:0] ST_FULL         = 3'd2;
  localparam logic [2:0] ST_EMPTY_CLOSED = 3'd3;
  localparam logic [2:0] ST_RETRY        = 3'd4;

  typedef struct packed {
    logic ins;
    logic urgent_mode;
    logic pop;
    logic nu_head;
  } tciq_ctl_t;

endpackage

### rtl/tciq_cell.sv
// One queue slot: tag, urgent mark and count of non-urgent entries ahead of it.
module tciq_cell #(
  parameter int IDX      = 0,
  parameter int TAG_BITS = 16,
  parameter int CW       = 4,
  parameter int NW       = 5
) (
  input  logic                clk,
  input  logic                rst,
  input  tciq_pkg::tciq_ctl_t ctl,
  input  logic [NW-1:0]       fill,
  input  logic [TAG_BITS-1:0] new_tag,
  input  logic                new_urg,
  input  logic [TAG_BITS-1:0] left_tag,
  input  logic                left_urg,
  input  logic [CW-1:0]       left_c,
  input  logic                left_after,
  input  logic [TAG_BITS-1:0] right_tag,
  input  logic                right_urg,
  input  logic [CW-1:0]       right_c,
  output logic [TAG_BITS-1:0] tag,
  output logic                urg,
  output logic [CW-1:0]       c,
  output logic                after
);
  import tciq_pkg::*;

  logic occ;

  assign occ   = NW'(IDX) < fill;
  assign after = ctl.urgent_mode ? ((c != '0) || !occ || !urg) : !occ;

  always_ff @(posedge clk) begin
    if (ctl.ins && after) begin
      if (left_after) begin
        tag <= left_tag;
        urg <= left_urg;
      end else begin
        tag <= new_tag;
        urg <= new_urg;
      end
    end else if (ctl.pop) begin
      tag <= right_tag;
      urg <= right_urg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c <= '0;
    end else if (ctl.ins && after && left_after) begin
      c <= left_c + CW'(!new_urg);
    end else if (ctl.pop) begin
      c <= right_c - CW'(ctl.nu_head);
    end
  end

endmodule

### rtl/two_class_insertion_queue_top.sv
// Top level of the two-class insertion queue: command decode, cell row, result register.
//
//   channel | direction | handshake              | payload
//   in      | input     | in_valid / in_ready    | opcode, item_tag, item_urgent
//   out     | output    | out_valid / out_ready  | status, out_tag, out_urgent, count,
//           |           |                        | closed_mark
//
// One command per cycle while in_ready is high: every cell decides locally where it stands against the
// insert point and moves in the same edge; the result is registered and appears in the next cycle.
// A new command is taken while the result register is empty or being emptied.
// Synchronous reset empties and opens the queue.
module two_class_insertion_queue_top #(
  parameter int CAPACITY = tciq_pkg::CAPACITY_DEF,
  parameter int TAG_BITS = tciq_pkg::TAG_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [2:0]                      opcode,
  input  logic [TAG_BITS-1:0]             item_tag,
  input  logic                            item_urgent,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [2:0]                      status,
  output logic [TAG_BITS-1:0]             out_tag,
  output logic                            out_urgent,
  output logic [$clog2(CAPACITY+1)-1:0]   count,
  output logic                            closed_mark
);
  import tciq_pkg::*;

  localparam int NW = $clog2(CAPACITY + 1);
  localparam int CW = $clog2(CAPACITY);

  logic [NW-1:0]       fill, fill_next;
  logic                closed, closed_next;
  logic                accept, push_ok, pop_ok, is_push;
  logic [2:0]          status_next;
  tciq_ctl_t           ctl;

  logic [TAG_BITS-1:0] tag_w   [CAPACITY];
  logic                urg_w   [CAPACITY];
  logic [CW-1:0]       c_w     [CAPACITY];
  logic                after_w [CAPACITY];

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign is_push  = (opcode == OP_PUSH) || (opcode == OP_URGENT);
  assign push_ok  = is_push && !closed && (fill != NW'(CAPACITY));
  assign pop_ok   = (opcode == OP_POP) && (fill != '0);

  assign ctl.ins         = accept && push_ok;
  assign ctl.urgent_mode = opcode == OP_URGENT;
  assign ctl.pop         = accept && pop_ok;
  assign ctl.nu_head     = !urg_w[0];

  always_comb begin
    fill_next   = fill;
    closed_next = closed;
    status_next = ST_OK;
    case (opcode)
      OP_PUSH, OP_URGENT: begin
        if (closed) begin
          status_next = ST_CLOSED;
        end else if (fill == NW'(CAPACITY)) begin
          status_next = ST_FULL;
        end else begin
          fill_next = fill + NW'(1);
        end
      end
      OP_POP: begin
        if (fill == '0) begin
          status_next = closed ? ST_EMPTY_CLOSED : ST_RETRY;
        end else begin
          fill_next = fill - NW'(1);
        end
      end
      OP_CLOSE: begin
        closed_next = 1'b1;
      end
      OP_QUERY: begin
        status_next = ST_OK;
      end
      default: begin
        status_next = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      closed    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        fill   <= fill_next;
        closed <= closed_next;
      end
      if (accept) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status      <= status_next;
      out_tag     <= pop_ok ? tag_w[0] : '0;
      out_urgent  <= pop_ok ? urg_w[0] : 1'b0;
      count       <= fill_next;
      closed_mark <= closed_next;
    end
  end

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic [TAG_BITS-1:0] l_tag, r_tag;
    logic                l_urg, r_urg, l_after;
    logic [CW-1:0]       l_c, r_c;

    if (k == 0) begin : g_first
      assign l_tag   = '0;
      assign l_urg   = 1'b0;
      assign l_c     = '0;
      assign l_after = 1'b0;
    end else begin : g_mid_l
      assign l_tag   = tag_w[k-1];
      assign l_urg   = urg_w[k-1];
      assign l_c     = c_w[k-1];
      assign l_after = after_w[k-1];
    end

    if (k == CAPACITY - 1) begin : g_last
      assign r_tag = '0;
      assign r_urg = 1'b0;
      assign r_c   = c_w[k] + CW'((fill == NW'(CAPACITY)) && !urg_w[k]);
    end else begin : g_mid_r
      assign r_tag = tag_w[k+1];
      assign r_urg = urg_w[k+1];
      assign r_c   = c_w[k+1];
    end

    tciq_cell #(
      .IDX      (k),
      .TAG_BITS (TAG_BITS),
      .CW       (CW),
      .NW       (NW)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .fill       (fill),
      .new_tag    (item_tag),
      .new_urg    (item_urgent),
      .left_tag   (l_tag),
      .left_urg   (l_urg),
      .left_c     (l_c),
      .left_after (l_after),
      .right_tag  (r_tag),
      .right_urg  (r_urg),
      .right_c    (r_c),
      .tag        (tag_w[k]),
      .urg        (urg_w[k]),
      .c          (c_w[k]),
      .after      (after_w[k])
    );
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= NW'(CAPACITY))
    else $error("fill exceeds capacity");

  a_pop_dec: assert property (@(posedge clk) disable iff (rst)
    ctl.pop |=> fill == $past(fill) - NW'(1))
    else $error("pop did not decrement fill");

  a_closed_sticky: assert property (@(posedge clk) disable iff (rst)
    closed |=> closed)
    else $error("closed mark cleared");

  a_head_count: assert property (@(posedge clk) disable iff (rst)
    c_w[0] == '0)
    else $error("head cell non-urgent count not zero");

  a_zero_payload: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_OK) |-> (out_tag == '0) && !out_urgent)
    else $error("payload set on rejected command");

endmodule
